[hdl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PCSP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define PCSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/pcsp_pkg.sv]
`default_nettype none

package pcsp_pkg;

   typedef enum logic [3:0] {
      EV_TEXT_BYTE   = 4'd0,
      EV_TEXT_END    = 4'd1,
      EV_LINE_FEED   = 4'd2,
      EV_UNDERLINE   = 4'd3,
      EV_LINE_SPACE  = 4'd4,
      EV_INIT        = 4'd5,
      EV_FEED_DOTS   = 4'd6,
      EV_JUSTIFY     = 4'd7,
      EV_FEED_LINES  = 4'd8,
      EV_REVERSE     = 4'd9,
      EV_LEFT_MARGIN = 4'd10,
      EV_TEXT_WIDTH  = 4'd11,
      EV_IMAGE_HDR   = 4'd12,
      EV_IMAGE_BYTE  = 4'd13
   } ev_type;

   localparam logic [7:0] CODE_ESC = 8'h1B;
   localparam logic [7:0] CODE_GS  = 8'h1D;
   localparam logic [7:0] CODE_CR  = 8'h0D;
   localparam logic [7:0] CODE_LF  = 8'h0A;

   localparam logic [7:0] ESC_SUB_UNDERLINE  = 8'h2D;
   localparam logic [7:0] ESC_SUB_LINE_SPACE = 8'h33;
   localparam logic [7:0] ESC_SUB_INIT       = 8'h40;
   localparam logic [7:0] ESC_SUB_FEED_DOTS  = 8'h4A;
   localparam logic [7:0] ESC_SUB_JUSTIFY    = 8'h61;
   localparam logic [7:0] ESC_SUB_FEED_LINES = 8'h64;
   localparam logic [7:0] GS_SUB_REVERSE     = 8'h42;
   localparam logic [7:0] GS_SUB_LEFT_MARGIN = 8'h4C;
   localparam logic [7:0] GS_SUB_PRINT_WIDTH = 8'h57;
   localparam logic [7:0] GS_SUB_RASTER      = 8'h76;

   localparam logic [15:0] PAPER_WIDTH_RESET = 16'd384;

   // width*height/8 fits in 29 bits
   localparam int IMG_COUNT_W = 29;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      ev_type      ev;
      logic [15:0] value;
      logic [15:0] height;
      logic [7:0]  data;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
   } push_type;

endpackage

`default_nettype wire

[hdl/pcsp_parser.sv]
`default_nettype none

module pcsp_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic [7:0]       data_byte,
   input  wire logic             last_byte,
   input  wire logic             csr_wr_en,
   input  wire logic [15:0]      csr_wr_data,
   output pcsp_pkg::push_type    push
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SUB, PH_P0, PH_P1, PH_P2, PH_P3, PH_IMG
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        gs_ff, gs_in;
   logic [7:0]  sub_ff, sub_in;
   logic [7:0]  p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [pcsp_pkg::IMG_COUNT_W-1:0] left_ff, left_in;
   logic        text_ff, text_in;
   logic        cr_ff, cr_in;
   logic [15:0] paper_ff, paper_in;

   logic [31:0]      product;
   logic [15:0]      v16;
   logic             prim_v;
   logic             extra;
   pcsp_pkg::rsp_type prim, tend;

   assign product  = 32'({p1_ff, p0_ff}) * 32'({data_byte, p2_ff});
   assign v16      = {data_byte, p0_ff};
   assign paper_in = csr_wr_en ? csr_wr_data : paper_ff;

   always_comb begin
      phase_in = phase_ff;
      gs_in    = gs_ff;
      sub_in   = sub_ff;
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      left_in  = left_ff;
      text_in  = text_ff;
      cr_in    = cr_ff;
      prim_v   = 1'b0;
      prim     = '0;
      extra    = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            priority if (data_byte == pcsp_pkg::CODE_ESC || data_byte == pcsp_pkg::CODE_GS) begin
               prim_v   = text_ff;
               prim.ev  = pcsp_pkg::EV_TEXT_END;
               text_in  = 1'b0;
               cr_in    = 1'b0;
               gs_in    = (data_byte == pcsp_pkg::CODE_GS);
               phase_in = PH_SUB;
            end else if (data_byte == pcsp_pkg::CODE_CR) begin
               prim_v  = 1'b1;
               prim.ev = text_ff ? pcsp_pkg::EV_TEXT_END : pcsp_pkg::EV_LINE_FEED;
               text_in = 1'b0;
               cr_in   = 1'b1;
            end else if (data_byte == pcsp_pkg::CODE_LF) begin
               prim_v  = text_ff | ~cr_ff;
               prim.ev = text_ff ? pcsp_pkg::EV_TEXT_END : pcsp_pkg::EV_LINE_FEED;
               text_in = 1'b0;
               cr_in   = 1'b0;
            end else begin
               prim_v    = 1'b1;
               prim.ev   = pcsp_pkg::EV_TEXT_BYTE;
               prim.data = data_byte;
               text_in   = 1'b1;
               cr_in     = 1'b0;
            end
         end
         PH_SUB: begin
            sub_in   = data_byte;
            phase_in = PH_P0;
         end
         PH_P0: begin
            p0_in      = data_byte;
            phase_in   = PH_IDLE;
            prim.value = {8'd0, data_byte};
            if (!gs_ff) begin
               prim_v = 1'b1;
               unique case (sub_ff)
                  pcsp_pkg::ESC_SUB_UNDERLINE:  prim.ev = pcsp_pkg::EV_UNDERLINE;
                  pcsp_pkg::ESC_SUB_LINE_SPACE: prim.ev = pcsp_pkg::EV_LINE_SPACE;
                  pcsp_pkg::ESC_SUB_INIT: begin
                     prim.ev    = pcsp_pkg::EV_INIT;
                     prim.value = '0;
                  end
                  pcsp_pkg::ESC_SUB_FEED_DOTS:  prim.ev = pcsp_pkg::EV_FEED_DOTS;
                  pcsp_pkg::ESC_SUB_JUSTIFY:    prim.ev = pcsp_pkg::EV_JUSTIFY;
                  pcsp_pkg::ESC_SUB_FEED_LINES: prim.ev = pcsp_pkg::EV_FEED_LINES;
                  default:                      prim_v  = 1'b0;
               endcase
            end else if (sub_ff == pcsp_pkg::GS_SUB_REVERSE) begin
               prim_v  = 1'b1;
               prim.ev = pcsp_pkg::EV_REVERSE;
            end else if (sub_ff == pcsp_pkg::GS_SUB_LEFT_MARGIN ||
                         sub_ff == pcsp_pkg::GS_SUB_PRINT_WIDTH ||
                         sub_ff == pcsp_pkg::GS_SUB_RASTER) begin
               phase_in = PH_P1;
            end
         end
         PH_P1: begin
            p1_in      = data_byte;
            phase_in   = PH_IDLE;
            prim.value = v16;
            priority if (sub_ff == pcsp_pkg::GS_SUB_LEFT_MARGIN) begin
               prim_v  = (v16 < paper_ff);
               prim.ev = pcsp_pkg::EV_LEFT_MARGIN;
            end else if (sub_ff == pcsp_pkg::GS_SUB_PRINT_WIDTH) begin
               prim_v  = (v16 <= paper_ff);
               prim.ev = pcsp_pkg::EV_TEXT_WIDTH;
            end else begin
               phase_in = PH_P2;
            end
         end
         PH_P2: begin
            p2_in    = data_byte;
            phase_in = PH_P3;
         end
         PH_P3: begin
            prim_v      = 1'b1;
            prim.ev     = pcsp_pkg::EV_IMAGE_HDR;
            prim.value  = {p1_ff, p0_ff};
            prim.height = {data_byte, p2_ff};
            left_in     = product[31:3];
            phase_in    = (product[31:3] != '0) ? PH_IMG : PH_IDLE;
         end
         PH_IMG: begin
            prim_v    = 1'b1;
            prim.ev   = pcsp_pkg::EV_IMAGE_BYTE;
            prim.data = data_byte;
            if (left_ff != '0) begin
               left_in = left_ff - pcsp_pkg::IMG_COUNT_W'(1);
            end
            if (left_in == '0) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      // end of stream
      if (last_byte) begin
         extra    = text_in;
         text_in  = 1'b0;
         cr_in    = 1'b0;
         phase_in = PH_IDLE;
         left_in  = '0;
      end
   end

   always_comb begin
      tend      = '0;
      tend.ev   = pcsp_pkg::EV_TEXT_END;
      tend.last = 1'b1;
      push      = '0;
      priority if (prim_v && extra) begin
         push.count = 2'd2;
         push.r0    = prim;
         push.r1    = tend;
      end else if (prim_v) begin
         push.count   = 2'd1;
         push.r0      = prim;
         push.r0.last = 1'b1;
      end else if (extra) begin
         push.count = 2'd1;
         push.r0    = tend;
      end else begin
         push.count = 2'd0;
      end
      if (!fire) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         gs_ff    <= 1'b0;
         sub_ff   <= '0;
         left_ff  <= '0;
         text_ff  <= 1'b0;
         cr_ff    <= 1'b0;
         paper_ff <= pcsp_pkg::PAPER_WIDTH_RESET;
      end else begin
         paper_ff <= paper_in;
         if (fire) begin
            phase_ff <= phase_in;
            gs_ff    <= gs_in;
            sub_ff   <= sub_in;
            left_ff  <= left_in;
            text_ff  <= text_in;
            cr_ff    <= cr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

endmodule

`default_nettype wire

[hdl/pcsp_rsp_fifo.sv]
`default_nettype none

module pcsp_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcsp_pkg::push_type push,
   output logic                   in_ready,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output pcsp_pkg::rsp_type      head
);

   pcsp_pkg::rsp_type mem_ff [pcsp_pkg::FIFO_DEPTH];

   logic [pcsp_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [pcsp_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pcsp_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic                            pop;

   assign out_valid = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;
   // room for the two beats one byte can produce
   assign in_ready  = (count_ff <= pcsp_pkg::FIFO_CNT_W'(pcsp_pkg::FIFO_DEPTH - 2));

   assign wr_next   = wr_ptr_ff + pcsp_pkg::FIFO_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + pcsp_pkg::FIFO_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + pcsp_pkg::FIFO_PTR_W'(pop);
   assign count_in  = count_ff + pcsp_pkg::FIFO_CNT_W'(push.count)
                      - pcsp_pkg::FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.r1;
      end
   end

endmodule

`default_nettype wire

[hdl/printer_command_stream_parser.sv]
// Receipt-printer command stream parser. Takes one stream byte per beat on req_
// and splits it into text bytes, text ends, line feeds, ESC/GS commands and raster
// image data on rsp_, one result per beat. A byte is accepted in every cycle while
// results drain; each byte yields zero, one or two results, which are registered
// into a four-entry queue and wait there. req_tready drops while fewer than two
// entries are free, so the output side sets the pace only when it stalls, or when
// a text byte that ends the stream brings its text end as a second beat. The
// image byte count is one 16x16 multiply, registered. paper_width_dots must be
// written through csr_ only while the block is idle; the block does not check it.
`default_nettype none

module printer_command_stream_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [15:0] value, [31:16] image_height,
                                         // [39:32] byte_out
   output logic [3:0]       rsp_tuser,   // event_res
   output logic             rsp_tlast,   // last_result
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data  // paper_width_dots
);

   logic               fire;
   pcsp_pkg::push_type push;
   pcsp_pkg::rsp_type  head;

   assign fire = req_tvalid & req_tready;

   pcsp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push)
   );

   pcsp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .head      (head)
   );

   assign rsp_tdata = {head.data, head.height, head.value};
   assign rsp_tuser = head.ev;
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire

[hdl/pcsp_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module pcsp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   logic carries_byte;
   logic stalled;
   logic is_text_end;
   logic is_hdr;

   assign carries_byte = (rsp_tuser == pcsp_pkg::EV_TEXT_BYTE) ||
                         (rsp_tuser == pcsp_pkg::EV_IMAGE_BYTE);
   assign stalled      = rsp_tvalid && !rsp_tready;
   assign is_text_end  = (rsp_tuser == pcsp_pkg::EV_TEXT_END);
   assign is_hdr       = (rsp_tuser == pcsp_pkg::EV_IMAGE_HDR);

   `PCSP_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata))
   `PCSP_ASSERT_IMPLY(a_text_end_last, clock, reset, rsp_tvalid && is_text_end, rsp_tlast)
   `PCSP_ASSERT_IMPLY(a_byte_zero, clock, reset, rsp_tvalid && !carries_byte, rsp_tdata[39:32] == 8'd0)
   `PCSP_ASSERT_IMPLY(a_height_zero, clock, reset, rsp_tvalid && !is_hdr, rsp_tdata[31:16] == 16'd0)
   `PCSP_ASSERT_IMPLY(a_event_range, clock, reset, rsp_tvalid, rsp_tuser <= pcsp_pkg::EV_IMAGE_BYTE)

endmodule

bind printer_command_stream_parser pcsp_checker u_pcsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
